// ----- rtl/xmodem_crc_sender_top_macros.svh -----
// Assertion macros shared by the sender's checker.
`ifndef XMODEM_CRC_SENDER_TOP_MACROS_SVH
`define XMODEM_CRC_SENDER_TOP_MACROS_SVH

// Plain property on the block clock, quiet while reset is held.
`define XCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A signal keeps its value in the cycle after a condition holds.
`define XCS_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

// ----- rtl/xcs_pkg.sv -----
// Types, protocol constants and the CRC step of the XMODEM-CRC sender.
package xcs_pkg;

    localparam int BLOCK_BYTES_DEF = 128;

    // Protocol bytes
    localparam logic [7:0] PAD_BYTE = 8'h1A;
    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] NAK_BYTE = 8'h15;
    localparam logic [7:0] CAN_BYTE = 8'h18;

    // Register reset values
    localparam logic [7:0] READY_CODE_RST    = 8'd67;
    localparam logic [7:0] ATTEMPT_LIMIT_RST = 8'd20;

    // Register map (word index)
    localparam logic REG_READY_CODE    = 1'b0;
    localparam logic REG_ATTEMPT_LIMIT = 1'b1;

    // Result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RETRIES   = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_EOT_NACK  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_SLOT    = 2'd1,
        CMD_REPLY   = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_t;

    typedef enum logic [11:0] {
        PH_WAIT_READY   = 12'b0000_0000_0001,
        PH_LOAD         = 12'b0000_0000_0010,
        PH_SEND         = 12'b0000_0000_0100,
        PH_WAIT_ACK     = 12'b0000_0000_1000,
        PH_EOT_SEND     = 12'b0000_0001_0000,
        PH_EOT_WAIT     = 12'b0000_0010_0000,
        PH_ABORT_CAN    = 12'b0000_0100_0000,
        PH_ABORT_UNK    = 12'b0000_1000_0000,
        PH_REPORT_RETRY = 12'b0001_0000_0000,
        PH_REPORT_CAN   = 12'b0010_0000_0000,
        PH_REPORT_UNK   = 12'b0100_0000_0000,
        PH_DONE         = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] tx_byte;
        logic [2:0] status;
    } xcs_result_t;

    // One byte of CRC-16, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/xcs_out_buf.sv -----
// Two-entry result buffer: output register plus skid stage.
module xcs_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  xcs_pkg::xcs_result_t in_result,
    output logic                 in_ready,
    output logic                 m_valid,
    output xcs_pkg::xcs_result_t m_result,
    input  logic                 m_ready
);
    import xcs_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    xcs_result_t out_data_reg;
    xcs_result_t skid_data_reg;
    logic        drain_skid;
    logic        load_out;
    logic        load_skid;

    // Skid drains first; new words go to the output when it frees up
    assign drain_skid = out_valid_reg && m_ready && skid_valid_reg;
    assign load_out   = !drain_skid && in_valid && (!out_valid_reg || m_ready);
    assign load_skid  = !drain_skid && in_valid && out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (drain_skid) begin
                skid_valid_reg <= 1'b0;
            end else if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (load_skid) begin
                skid_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (drain_skid) begin
            out_data_reg <= skid_data_reg;
        end else if (load_out) begin
            out_data_reg <= in_result;
        end
        if (load_skid) begin
            skid_data_reg <= in_result;
        end
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

endmodule

// ----- rtl/xmodem_crc_sender_top.sv -----
// XMODEM-CRC sender: protocol sequencer, block buffer and APB registers.
//
// Takes one input word per cycle, back to back, while s_ready is high, with
// a result (a line byte or the final status) at most one per word, registered
// at acceptance. The whole protocol step, including a byte-wide CRC-16
// update, is done combinationally from the accepted word to the result
// register. The block buffer is a RAM with one write port and one registered
// read port; the read is fetched one slot ahead from the next send position,
// so payload bytes also go out one per cycle while s_ready is high.
// A two-entry output buffer keeps input flowing while a result waits; input
// stalls only when both entries are full. The buffer needs no clearing after
// reset: bytes past the fill count are sent as 0x1A padding. Registers:
// ready_code at 0x0, attempt_limit at 0x4 (low 8 bits of pwdata); write them
// only while the block is idle.
module xmodem_crc_sender_top #(
    parameter int BLOCK_BYTES = xcs_pkg::BLOCK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_of_image,
    // Results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_kind,
    output logic [7:0]  m_tx_byte,
    output logic [2:0]  m_status
);
    import xcs_pkg::*;

    localparam int ADDR_W = $clog2(BLOCK_BYTES);
    localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
    localparam int POS_W  = $clog2(BLOCK_BYTES + 5);

    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BLOCK_BYTES);
    localparam logic [POS_W-1:0] DATA_POS  = POS_W'(3);
    localparam logic [POS_W-1:0] CRC_H_POS = POS_W'(BLOCK_BYTES + 3);

    // Configuration
    logic [7:0] ready_code_reg;
    logic [7:0] attempt_limit_reg;

    // Protocol state
    phase_t           phase_reg,    phase_next;
    logic [CNT_W-1:0] fill_reg,     fill_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       seq_reg,      seq_next;
    logic [7:0]       attempts_reg, attempts_next;
    logic [15:0]      crc_reg,      crc_next;
    logic             fin_reg,      fin_next;

    // Block buffer
    logic [7:0]        buf_mem [BLOCK_BYTES];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  data_idx;
    logic [CNT_W-1:0]  fill_inc;
    logic [7:0]        pay_byte;

    logic        accept;
    cmd_t        cmd;
    logic        res_valid;
    xcs_result_t res;
    xcs_result_t m_result;

    // APB register file
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ATTEMPT_LIMIT) ? {24'd0, attempt_limit_reg}
                                                    : {24'd0, ready_code_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_code_reg    <= READY_CODE_RST;
            attempt_limit_reg <= ATTEMPT_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_ATTEMPT_LIMIT) begin
                attempt_limit_reg <= pwdata[7:0];
            end else begin
                ready_code_reg <= pwdata[7:0];
            end
        end
    end

    assign accept   = s_valid && s_ready;
    assign cmd      = cmd_t'(s_command);
    assign data_idx = CNT_W'(pos_reg - DATA_POS);
    assign fill_inc = fill_reg + CNT_W'(1);
    assign pay_byte = (data_idx < fill_reg) ? rd_data_reg : PAD_BYTE;

    // One protocol step per accepted word
    always_comb begin
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        seq_next      = seq_reg;
        attempts_next = attempts_reg;
        crc_next      = crc_reg;
        fin_next      = fin_reg;
        mem_we        = 1'b0;
        res_valid     = 1'b0;
        res           = '{out_kind: KIND_BYTE, tx_byte: 8'd0, status: ST_OK};

        if (accept) begin
            case (cmd)
                CMD_LOAD: begin
                    if (phase_reg == PH_LOAD && fill_reg < FULL_CNT) begin
                        mem_we    = 1'b1;
                        fill_next = fill_inc;
                        if (s_last_of_image) begin
                            fin_next = 1'b1;
                        end
                        if (fill_inc == FULL_CNT || s_last_of_image) begin
                            phase_next    = PH_SEND;
                            pos_next      = '0;
                            attempts_next = attempt_limit_reg;
                        end
                    end
                end
                CMD_SLOT: begin
                    case (phase_reg)
                        PH_SEND: begin
                            res_valid = 1'b1;
                            if (pos_reg == '0) begin
                                if (attempts_reg == 8'd0) begin
                                    phase_next  = PH_REPORT_RETRY;
                                    res.tx_byte = EOT_BYTE;
                                end else begin
                                    attempts_next = attempts_reg - 8'd1;
                                    crc_next      = 16'd0;
                                    pos_next      = POS_W'(1);
                                    res.tx_byte   = SOH_BYTE;
                                end
                            end else if (pos_reg == POS_W'(1)) begin
                                pos_next    = POS_W'(2);
                                res.tx_byte = seq_reg;
                            end else if (pos_reg == POS_W'(2)) begin
                                pos_next    = DATA_POS;
                                res.tx_byte = ~seq_reg;
                            end else if (pos_reg < CRC_H_POS) begin
                                crc_next    = crc16_step(crc_reg, pay_byte);
                                pos_next    = pos_reg + POS_W'(1);
                                res.tx_byte = pay_byte;
                            end else if (pos_reg == CRC_H_POS) begin
                                pos_next    = pos_reg + POS_W'(1);
                                res.tx_byte = crc_reg[15:8];
                            end else begin
                                pos_next    = '0;
                                phase_next  = PH_WAIT_ACK;
                                res.tx_byte = crc_reg[7:0];
                            end
                        end
                        PH_EOT_SEND: begin
                            res_valid   = 1'b1;
                            res.tx_byte = EOT_BYTE;
                            phase_next  = PH_EOT_WAIT;
                        end
                        PH_ABORT_CAN: begin
                            res_valid   = 1'b1;
                            res.tx_byte = EOT_BYTE;
                            phase_next  = PH_REPORT_CAN;
                        end
                        PH_ABORT_UNK: begin
                            res_valid   = 1'b1;
                            res.tx_byte = EOT_BYTE;
                            phase_next  = PH_REPORT_UNK;
                        end
                        PH_REPORT_RETRY: begin
                            res_valid    = 1'b1;
                            res.out_kind = KIND_STATUS;
                            res.status   = ST_RETRIES;
                            phase_next   = PH_DONE;
                        end
                        PH_REPORT_CAN: begin
                            res_valid    = 1'b1;
                            res.out_kind = KIND_STATUS;
                            res.status   = ST_CANCELLED;
                            phase_next   = PH_DONE;
                        end
                        PH_REPORT_UNK: begin
                            res_valid    = 1'b1;
                            res.out_kind = KIND_STATUS;
                            res.status   = ST_UNKNOWN;
                            phase_next   = PH_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_REPLY: begin
                    case (phase_reg)
                        PH_WAIT_READY: begin
                            if (s_data_byte == ready_code_reg) begin
                                phase_next = PH_LOAD;
                                fill_next  = '0;
                            end
                        end
                        PH_WAIT_ACK: begin
                            if (s_data_byte == ACK_BYTE) begin
                                seq_next   = seq_reg + 8'd1;
                                fill_next  = '0;
                                phase_next = fin_reg ? PH_EOT_SEND : PH_LOAD;
                            end else if (s_data_byte == NAK_BYTE) begin
                                pos_next   = '0;
                                phase_next = PH_SEND;
                            end else if (s_data_byte == CAN_BYTE) begin
                                phase_next = PH_ABORT_CAN;
                            end else begin
                                phase_next = PH_ABORT_UNK;
                            end
                        end
                        PH_EOT_WAIT: begin
                            res_valid    = 1'b1;
                            res.out_kind = KIND_STATUS;
                            res.status   = (s_data_byte == ACK_BYTE) ? ST_OK : ST_EOT_NACK;
                            phase_next   = PH_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_TIMEOUT: begin
                    if (phase_reg inside {PH_WAIT_READY, PH_WAIT_ACK, PH_EOT_WAIT}) begin
                        res_valid    = 1'b1;
                        res.out_kind = KIND_STATUS;
                        res.status   = ST_TIMEOUT;
                        phase_next   = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT_READY;
            fill_reg     <= '0;
            pos_reg      <= '0;
            seq_reg      <= 8'd1;
            attempts_reg <= 8'd0;
            crc_reg      <= 16'd0;
            fin_reg      <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            seq_reg      <= seq_next;
            attempts_reg <= attempts_next;
            crc_reg      <= crc_next;
            fin_reg      <= fin_next;
        end
    end

    // Buffer RAM: read address tracks the next send position, so the byte
    // for the coming payload slot is already registered
    assign rd_addr = ADDR_W'(pos_next - DATA_POS);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            buf_mem[fill_reg[ADDR_W-1:0]] <= s_data_byte;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    // Result register and skid stage
    xcs_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_result (res),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_result  (m_result),
        .m_ready   (m_ready)
    );

    assign m_out_kind = m_result.out_kind;
    assign m_tx_byte  = m_result.tx_byte;
    assign m_status   = m_result.status;

endmodule

// ----- rtl/xcs_checker.sv -----
// Port-level checks for the XMODEM-CRC sender, bound to the top level.
`include "xmodem_crc_sender_top_macros.svh"

module xcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_out_kind,
    input logic [7:0] m_tx_byte,
    input logic [2:0] m_status
);
    logic        done_reg;
    logic [11:0] result_word;

    // Whole result payload as one vector
    assign result_word = {m_out_kind, m_tx_byte, m_status};

    // Remember that the final status word has been taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (m_valid && m_ready && m_out_kind) begin
            done_reg <= 1'b1;
        end
    end

    // Stalled result keeps its payload
    `XCS_ASSERT_HOLD(a_hold_payload, m_valid && !m_ready, result_word, "stalled result changed")

    // Input only backs up when a result is waiting at the output
    `XCS_ASSERT(a_stall_cause, !s_ready |-> m_valid, "input stalled with empty output")

    // Nothing follows the final status
    `XCS_ASSERT(a_after_done, done_reg |-> !m_valid, "result after final status")

endmodule

bind xmodem_crc_sender_top xcs_checker u_xcs_checker (.*);
